// ===== rtl/csr_graph_builder_assert.svh =====
// Assertion macros for the graph builder's RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef CSR_GRAPH_BUILDER_ASSERT_SVH
`define CSR_GRAPH_BUILDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CSRGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csr graph builder check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csr graph builder check failed");

`else

`define CSRGB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CSRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/csrgb_pkg.sv =====
package csrgb_pkg;

    // Field and register widths.
    localparam int FUNC_W     = 3;
    localparam int VTX_W      = 32;
    localparam int POS_W      = 12;
    localparam int RES_W      = 13;
    localparam int STATUS_W   = 2;
    localparam int BS_W       = 32;
    localparam int PI_W       = 16;
    localparam int NV_W       = 11;
    localparam int BASE_W     = BS_W + PI_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default sizes of the two stores.
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;

    // Register reset values.
    localparam logic [BS_W-1:0] BLOCK_SIZE_RST = BS_W'(1024);

    // Function codes.
    localparam logic [FUNC_W-1:0] FN_BEGIN  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FINISH = 3'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_INDEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES    = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_RANGE,
        ST_UNSORTED,
        ST_FULL
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_Q1,
        S_Q2,
        S_COL
    } t_state;

endpackage

// ===== rtl/csrgb_ram.sv =====
module csrgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/csr_graph_builder.sv =====
// Builds the CSR adjacency of one graph partition and answers lookups on it. Drive an item with
// start while busy is low; its single result word appears with o_valid for exactly one cycle and
// cannot be held off. Begin, rejected items and unknown codes answer from S_EXEC; a stored edge
// first writes any missing row pointers in S_FILL (the rows the source skipped and its own row);
// finish fills every remaining row through entry num_vertices, capped at MAX_VERTICES; a column
// read passes S_COL and a neighbor query S_Q1 then S_Q2, since the row-pointer memory has a
// single read port and gives both ends of a row in two reads. Busy drops when the result is
// registered, so the next item can be taken in the cycle the strobe shows. Configuration must
// be written through i_cfg_we only while the block is idle; the block does not enforce this.
module csr_graph_builder #(
    parameter int MAX_VERTICES = csrgb_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = csrgb_pkg::MAX_EDGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [csrgb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csrgb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [csrgb_pkg::FUNC_W-1:0]        i_func,
    input  logic [csrgb_pkg::VTX_W-1:0]         i_vertex,
    input  logic [csrgb_pkg::VTX_W-1:0]         i_target,
    input  logic [csrgb_pkg::POS_W-1:0]         i_position,
    output logic                                o_valid,
    output logic [csrgb_pkg::STATUS_W-1:0]      o_status,
    output logic [csrgb_pkg::RES_W-1:0]         o_start_res,
    output logic [csrgb_pkg::RES_W-1:0]         o_count,
    output logic [csrgb_pkg::VTX_W-1:0]         o_neighbor
);

`include "csr_graph_builder_assert.svh"

    localparam int RA_W   = $clog2(MAX_VERTICES + 1);
    localparam int RF_W   = $clog2(MAX_VERTICES + 2);
    localparam int ET_W   = $clog2(MAX_EDGES + 1);
    localparam int CA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DIFF_W = csrgb_pkg::BASE_W + 1;

    // Configuration registers and the derived partition base.
    logic [csrgb_pkg::BS_W-1:0]   r_block_size;
    logic [csrgb_pkg::PI_W-1:0]   r_partition_index;
    logic [csrgb_pkg::NV_W-1:0]   r_num_vertices;
    logic [csrgb_pkg::BASE_W-1:0] r_base;

    // Control state.
    csrgb_pkg::t_state r_state, n_state;
    logic [RF_W-1:0]   r_rows_filled, n_rows_filled;
    logic [ET_W-1:0]   r_edge_total, n_edge_total;
    logic              r_valid, n_valid;

    // Item and working registers.
    logic [csrgb_pkg::FUNC_W-1:0] r_func;
    logic [csrgb_pkg::VTX_W-1:0]  r_vertex;
    logic [csrgb_pkg::VTX_W-1:0]  r_target;
    logic [csrgb_pkg::POS_W-1:0]  r_position;
    logic [RA_W-1:0]              r_loc, n_loc;
    logic [RA_W-1:0]              r_limit, n_limit;
    logic                         r_fill_add, n_fill_add;
    logic [ET_W-1:0]              r_start, n_start;

    // Result registers.
    csrgb_pkg::t_status           r_status, n_status;
    logic [csrgb_pkg::RES_W-1:0]  r_start_res, n_start_res;
    logic [csrgb_pkg::RES_W-1:0]  r_count, n_count;
    logic [csrgb_pkg::VTX_W-1:0]  r_neighbor, n_neighbor;

    // Memory ports.
    logic                         row_we;
    logic [RA_W-1:0]              row_waddr, row_raddr;
    logic [ET_W-1:0]              row_wdata, row_rdata;
    logic                         col_we;
    logic [CA_W-1:0]              col_waddr, col_raddr;
    logic [csrgb_pkg::VTX_W-1:0]  col_wdata, col_rdata;

    // Item checks.
    logic              accept;
    logic [DIFF_W-1:0] diff;
    logic [RA_W-1:0]   nv_eff;
    logic [RA_W-1:0]   loc;
    logic              in_range;
    logic              unsorted;
    logic              full;
    logic              need_fill;
    logic              fin_fill;
    logic              q_ok;
    logic              rd_ok;
    logic              fill_last;

    assign busy   = (r_state != csrgb_pkg::S_IDLE);
    assign accept = start && !busy;

    assign nv_eff = (32'(r_num_vertices) > 32'(MAX_VERTICES)) ? RA_W'(MAX_VERTICES)
                                                              : RA_W'(r_num_vertices);

    // A borrow out of the subtraction means the vertex lies below the partition base.
    assign diff      = DIFF_W'(r_vertex) - DIFF_W'(r_base);
    assign in_range  = !diff[DIFF_W-1]
                    && (diff[csrgb_pkg::BASE_W-1:0] < csrgb_pkg::BASE_W'(nv_eff));
    assign loc       = RA_W'(diff);
    assign unsorted  = 32'(r_rows_filled) > (32'(loc) + 32'd1);
    assign full      = 32'(r_edge_total) >= 32'(MAX_EDGES);
    assign need_fill = 32'(r_rows_filled) <= 32'(loc);
    assign fin_fill  = 32'(r_rows_filled) <= 32'(nv_eff);
    assign q_ok      = in_range && ((32'(loc) + 32'd1) < 32'(r_rows_filled));
    assign rd_ok     = (32'(r_position) < 32'(r_edge_total))
                    && (32'(r_position) < 32'(MAX_EDGES));
    assign fill_last = 32'(r_rows_filled) == 32'(r_limit);

    csrgb_ram #(
        .WIDTH (ET_W),
        .DEPTH (MAX_VERTICES + 1)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    csrgb_ram #(
        .WIDTH (csrgb_pkg::VTX_W),
        .DEPTH (MAX_EDGES)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            csrgb_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = csrgb_pkg::S_EXEC;
                end
            end
            csrgb_pkg::S_EXEC: begin
                n_state = csrgb_pkg::S_IDLE;
                case (r_func)
                    csrgb_pkg::FN_ADD: begin
                        if (in_range && !unsorted && !full && need_fill) begin
                            n_state = csrgb_pkg::S_FILL;
                        end
                    end
                    csrgb_pkg::FN_FINISH: begin
                        if (fin_fill) begin
                            n_state = csrgb_pkg::S_FILL;
                        end
                    end
                    csrgb_pkg::FN_QUERY: begin
                        if (q_ok) begin
                            n_state = csrgb_pkg::S_Q1;
                        end
                    end
                    csrgb_pkg::FN_READ: begin
                        if (rd_ok) begin
                            n_state = csrgb_pkg::S_COL;
                        end
                    end
                    default: begin
                        n_state = csrgb_pkg::S_IDLE;
                    end
                endcase
            end
            csrgb_pkg::S_FILL: begin
                if (fill_last) begin
                    n_state = csrgb_pkg::S_IDLE;
                end
            end
            csrgb_pkg::S_Q1: begin
                n_state = csrgb_pkg::S_Q2;
            end
            csrgb_pkg::S_Q2, csrgb_pkg::S_COL: begin
                n_state = csrgb_pkg::S_IDLE;
            end
            default: begin
                n_state = csrgb_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and results.
    always_comb begin
        n_rows_filled = r_rows_filled;
        n_edge_total  = r_edge_total;
        n_loc         = r_loc;
        n_limit       = r_limit;
        n_fill_add    = r_fill_add;
        n_start       = r_start;
        n_valid       = 1'b0;
        n_status      = csrgb_pkg::ST_OK;
        n_start_res   = '0;
        n_count       = '0;
        n_neighbor    = '0;
        row_we        = 1'b0;
        row_waddr     = RA_W'(r_rows_filled);
        row_wdata     = r_edge_total;
        row_raddr     = loc;
        col_we        = 1'b0;
        col_waddr     = CA_W'(r_edge_total);
        col_wdata     = r_target;
        col_raddr     = CA_W'(r_position);

        case (r_state)
            csrgb_pkg::S_EXEC: begin
                case (r_func)
                    csrgb_pkg::FN_BEGIN: begin
                        n_rows_filled = '0;
                        n_edge_total  = '0;
                        n_valid       = 1'b1;
                    end
                    csrgb_pkg::FN_ADD: begin
                        if (!in_range) begin
                            n_valid  = 1'b1;
                            n_status = csrgb_pkg::ST_RANGE;
                        end else if (unsorted) begin
                            n_valid  = 1'b1;
                            n_status = csrgb_pkg::ST_UNSORTED;
                        end else if (full) begin
                            n_valid  = 1'b1;
                            n_status = csrgb_pkg::ST_FULL;
                        end else if (need_fill) begin
                            n_limit    = loc;
                            n_fill_add = 1'b1;
                        end else begin
                            col_we       = 1'b1;
                            n_edge_total = r_edge_total + 1'b1;
                            n_valid      = 1'b1;
                        end
                    end
                    csrgb_pkg::FN_FINISH: begin
                        if (fin_fill) begin
                            n_limit    = nv_eff;
                            n_fill_add = 1'b0;
                        end else begin
                            n_valid = 1'b1;
                        end
                    end
                    csrgb_pkg::FN_QUERY: begin
                        if (q_ok) begin
                            n_loc = loc;
                        end else begin
                            n_valid  = 1'b1;
                            n_status = csrgb_pkg::ST_RANGE;
                        end
                    end
                    csrgb_pkg::FN_READ: begin
                        if (!rd_ok) begin
                            n_valid  = 1'b1;
                            n_status = csrgb_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                    end
                endcase
            end
            csrgb_pkg::S_FILL: begin
                // Every skipped row starts where the next stored edge will go.
                row_we        = 1'b1;
                n_rows_filled = r_rows_filled + 1'b1;
                if (fill_last) begin
                    n_valid = 1'b1;
                    if (r_fill_add) begin
                        col_we       = 1'b1;
                        n_edge_total = r_edge_total + 1'b1;
                    end
                end
            end
            csrgb_pkg::S_Q1: begin
                n_start   = row_rdata;
                row_raddr = r_loc + 1'b1;
            end
            csrgb_pkg::S_Q2: begin
                n_valid     = 1'b1;
                n_start_res = csrgb_pkg::RES_W'(r_start);
                n_count     = csrgb_pkg::RES_W'(row_rdata - r_start);
            end
            csrgb_pkg::S_COL: begin
                n_valid    = 1'b1;
                n_neighbor = col_rdata;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= csrgb_pkg::S_IDLE;
            r_rows_filled     <= '0;
            r_edge_total      <= '0;
            r_valid           <= 1'b0;
            r_block_size      <= csrgb_pkg::BLOCK_SIZE_RST;
            r_partition_index <= '0;
            r_num_vertices    <= '0;
        end else begin
            r_state       <= n_state;
            r_rows_filled <= n_rows_filled;
            r_edge_total  <= n_edge_total;
            r_valid       <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csrgb_pkg::CFG_BLOCK_SIZE: begin
                        r_block_size <= i_cfg_data;
                    end
                    csrgb_pkg::CFG_PARTITION_INDEX: begin
                        r_partition_index <= i_cfg_data[csrgb_pkg::PI_W-1:0];
                    end
                    csrgb_pkg::CFG_NUM_VERTICES: begin
                        r_num_vertices <= i_cfg_data[csrgb_pkg::NV_W-1:0];
                    end
                    default: begin
                        r_num_vertices <= r_num_vertices;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // The base is registered; an item taken with a register write still uses the old base.
        r_base      <= r_block_size * r_partition_index;
        r_loc       <= n_loc;
        r_limit     <= n_limit;
        r_fill_add  <= n_fill_add;
        r_start     <= n_start;
        r_status    <= n_status;
        r_start_res <= n_start_res;
        r_count     <= n_count;
        r_neighbor  <= n_neighbor;
        if (accept) begin
            r_func     <= i_func;
            r_vertex   <= i_vertex;
            r_target   <= i_target;
            r_position <= i_position;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_start_res = r_start_res;
    assign o_count     = r_count;
    assign o_neighbor  = r_neighbor;

    `CSRGB_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, r_state == csrgb_pkg::S_FILL, 32'(r_rows_filled) <= 32'(r_limit))
    `CSRGB_ASSERT_NOW(a_edge_bound, i_clk, i_rst_n, 1'b1, 32'(r_edge_total) <= 32'(MAX_EDGES))
    `CSRGB_ASSERT_NOW(a_col_room, i_clk, i_rst_n, col_we, 32'(r_edge_total) < 32'(MAX_EDGES))
    `CSRGB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `CSRGB_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_valid, r_state == csrgb_pkg::S_IDLE)

endmodule
